// ----- design/rmd_pkg.sv -----
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared widths and the word type passed along the divider cell chain.
// ----------------------------------------------------------------------------
package rmd_pkg;

  localparam int unsigned Width    = 32;
  localparam int unsigned QBits    = Width - 1;
  localparam int unsigned DivSteps = QBits;
  localparam int unsigned ProdBits = 2 * Width - 1;

  typedef struct packed {
    logic [QBits-1:0] rem;
    logic [QBits-1:0] lo;
    logic [Width-1:0] div;
    logic             neg;
    logic             err;
  } rmd_cell_t;

endpackage

// ----- design/rmd_front.sv -----
// ----------------------------------------------------------------------------
// rmd_front
// Three-rank front end: magnitudes and signs, 32x32 multiply, rounding add
// and overflow check; loads the first divider cell word.
// ----------------------------------------------------------------------------
module rmd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [rmd_pkg::Width-1:0] multiplicand_i,
  input  logic signed [rmd_pkg::Width-1:0] multiplier_i,
  input  logic signed [rmd_pkg::Width-1:0] divisor_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output rmd_pkg::rmd_cell_t            word_o
);
  import rmd_pkg::*;

  // rank 1: magnitudes
  logic             v1_q, v2_q, v3_q;
  logic             rdy1, rdy2, rdy3;
  logic [Width-1:0] amag_q, bmag_q, dmag1_q;
  logic             neg1_q, err1_q;
  logic [Width-1:0] amag_d, bmag_d, dmag_d;
  logic             a_neg, a_pos, a_flip_neg, neg_d, err_d;

  // rank 2: product
  logic [ProdBits-1:0] prod_q;
  logic [Width-1:0]    dmag2_q;
  logic                neg2_q, err2_q;
  logic [2*Width-1:0]  prod_full;

  // rank 3: rounded dividend
  logic [ProdBits-1:0] num;
  logic                ovf;
  rmd_cell_t           word_q, word_d;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_q;
  assign word_o  = word_q;

  always_comb begin
    a_neg      = multiplicand_i[Width-1];
    a_pos      = !a_neg && (multiplicand_i != '0);
    amag_d     = a_neg ? (~multiplicand_i + 1'b1) : multiplicand_i;
    bmag_d     = multiplier_i[Width-1] ? (~multiplier_i + 1'b1) : multiplier_i;
    dmag_d     = divisor_i[Width-1] ? (~divisor_i + 1'b1) : divisor_i;
    a_flip_neg = divisor_i[Width-1] ? a_pos : a_neg;
    neg_d      = a_flip_neg ^ multiplier_i[Width-1];
    err_d      = (divisor_i == '0);
  end

  assign prod_full = amag_q * bmag_q;

  always_comb begin
    num         = prod_q + {{(ProdBits-QBits){1'b0}}, dmag2_q[Width-1:1]};
    ovf         = ({1'b0, num[ProdBits-1:QBits]} >= {1'b0, dmag2_q});
    word_d.rem  = num[ProdBits-2:QBits];
    word_d.lo   = num[QBits-1:0];
    word_d.div  = dmag2_q;
    word_d.neg  = neg2_q;
    word_d.err  = err2_q || ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      amag_q  <= amag_d;
      bmag_q  <= bmag_d;
      dmag1_q <= dmag_d;
      neg1_q  <= neg_d;
      err1_q  <= err_d;
    end
    if (rdy2 && v1_q) begin
      prod_q  <= prod_full[ProdBits-1:0];
      dmag2_q <= dmag1_q;
      neg2_q  <= neg1_q;
      err2_q  <= err1_q;
    end
    if (rdy3 && v2_q) begin
      word_q <= word_d;
    end
  end

endmodule

// ----- design/rmd_div_cell.sv -----
// ----------------------------------------------------------------------------
// rmd_div_cell
// One restoring division step: shifts in a dividend bit, trial-subtracts the
// divisor and shifts the quotient bit into the low word.
// ----------------------------------------------------------------------------
module rmd_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  rmd_pkg::rmd_cell_t word_i,
  output logic               valid_o,
  input  logic               ready_i,
  output rmd_pkg::rmd_cell_t word_o
);
  import rmd_pkg::*;

  logic             valid_q;
  rmd_cell_t        word_q, word_d;
  logic [Width:0]   diff;
  logic             ge;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_comb begin
    diff       = {1'b0, word_i.rem, word_i.lo[QBits-1]} - {1'b0, word_i.div};
    ge         = !diff[Width];
    word_d     = word_i;
    word_d.rem = ge ? diff[QBits-1:0] : {word_i.rem[QBits-2:0], word_i.lo[QBits-1]};
    word_d.lo  = {word_i.lo[QBits-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

endmodule

// ----- design/rmd_back.sv -----
// ----------------------------------------------------------------------------
// rmd_back
// Output register: applies the result sign, substitutes -1 on error.
// ----------------------------------------------------------------------------
module rmd_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  rmd_pkg::rmd_cell_t               word_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic signed [rmd_pkg::Width-1:0] quotient_o,
  output logic                             error_flag_o
);
  import rmd_pkg::*;

  logic             valid_q;
  logic [Width-1:0] quot_q, quot_d, mag;
  logic             err_q;

  assign ready_o      = !valid_q || ready_i;
  assign valid_o      = valid_q;
  assign quotient_o   = quot_q;
  assign error_flag_o = err_q;

  always_comb begin
    mag = {1'b0, word_i.lo};
    if (word_i.err) begin
      quot_d = '1;
    end else if (word_i.neg) begin
      quot_d = ~mag + 1'b1;
    end else begin
      quot_d = mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      quot_q <= quot_d;
      err_q  <= word_i.err;
    end
  end

endmodule

// ----- design/rounded_mul_div_32_top.sv -----
// ----------------------------------------------------------------------------
// rounded_mul_div_32_top
// Pipelined a*b/d rounded half away from zero, error on zero divisor or
// quotient outside +/-2147483647.
//
//   channel | ports                                    | dir
//   --------+------------------------------------------+----
//   in      | in_valid_i, in_ready_o, multiplicand_i,  | in
//           | multiplier_i, divisor_i                  |
//   out     | out_valid_o, out_ready_i, quotient_o,    | out
//           | error_flag_o                             |
//
// One word per cycle while not back-pressured; three front ranks (magnitudes,
// 32x32 multiply, rounding add), 31 division cells, one output register.
// Each rank holds its own valid bit, so bubbles collapse under back-pressure.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module rounded_mul_div_32_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [rmd_pkg::Width-1:0] multiplicand_i,
  input  logic signed [rmd_pkg::Width-1:0] multiplier_i,
  input  logic signed [rmd_pkg::Width-1:0] divisor_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [rmd_pkg::Width-1:0] quotient_o,
  output logic                             error_flag_o
);
  import rmd_pkg::*;

  rmd_cell_t           chain_word  [DivSteps+1];
  logic [DivSteps:0]   chain_valid;
  logic [DivSteps:0]   chain_ready;

  rmd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .ready_o        (in_ready_o),
    .multiplicand_i (multiplicand_i),
    .multiplier_i   (multiplier_i),
    .divisor_i      (divisor_i),
    .valid_o        (chain_valid[0]),
    .ready_i        (chain_ready[0]),
    .word_o         (chain_word[0])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    rmd_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[i]),
      .ready_o (chain_ready[i]),
      .word_i  (chain_word[i]),
      .valid_o (chain_valid[i+1]),
      .ready_i (chain_ready[i+1]),
      .word_o  (chain_word[i+1])
    );
  end

  rmd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (chain_valid[DivSteps]),
    .ready_o      (chain_ready[DivSteps]),
    .word_i       (chain_word[DivSteps]),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .quotient_o   (quotient_o),
    .error_flag_o (error_flag_o)
  );

endmodule
